// ----- design/goc_pkg.sv -----
`default_nettype none
package goc_pkg;

  // geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int REG_W      = 11;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [REG_W-1:0] REG_MIN      = 11'd3;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // angle codes
  localparam int ANG_STEPS = 90;
  localparam logic signed [7:0] ANG_NONE = 8'sd100;
  localparam logic signed [7:0] ANG_FLAT = -8'sd90;
  localparam logic [8:0] ANG_OFFSET = 9'd90;
  localparam logic [2:0] BIN_NONE = 3'd6;

  // one interior pixel handed from front to back
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              last;
  } goc_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_SUM,
    S_MAGA,
    S_MAGB,
    S_ANG,
    S_DONE
  } goc_back_state_t;

  // sine of (j + 0.5) degrees, unsigned Q54
  typedef logic [53:0] goc_sin_tab_t [0:ANG_STEPS-1];

  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C235;
  localparam logic [63:0] STEP_Q62 = PI_Q62 / 360;

  function automatic logic [63:0] goc_mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  function automatic goc_sin_tab_t goc_build_sin();
    goc_sin_tab_t tab;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    for (int j = 0; j < ANG_STEPS; j++) begin
      x    = STEP_Q62 * 64'(2 * j + 1);
      x2   = goc_mul_q62(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 15; k++) begin
        term = goc_mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - term;
        else sum = sum + term;
      end
      tab[j] = sum[61:8];
    end
    return tab;
  endfunction

  localparam goc_sin_tab_t SIN_Q54 = goc_build_sin();

  // saturate a register write into 3..hi
  function automatic logic [REG_W-1:0] goc_clamp(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] x;
    x = v;
    if (x < REG_MIN) x = REG_MIN;
    if (x > hi) x = hi;
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- design/goc_front.sv -----
`default_nettype none
module goc_front import goc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [7:0]       gray_pixel,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  input  wire logic             q_full,
  output logic                  full,
  output logic                  q_push,
  output goc_item_t             q_item
);

  localparam logic [REG_W-1:0] WIDTH_MAX  = REG_W'(MAX_WIDTH);
  localparam logic [REG_W-1:0] HEIGHT_MAX = REG_W'(MAX_HEIGHT);

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [COL_W-1:0] col_counter;
  logic [ROW_W-1:0] row_counter;
  logic             busy;
  logic [7:0]       pix_hold;
  logic [COL_W-1:0] c_hold;
  logic [7:0]       rd_above;
  logic [7:0]       rd_two;
  logic [7:0]       w0, w1, w3, w5;

  logic [7:0] line_above     [0:MAX_WIDTH-1];
  logic [7:0] line_two_above [0:MAX_WIDTH-1];

  logic             accept;
  logic [COL_W-1:0] c_use;
  logic [REG_W-1:0] c_inc;
  logic [REG_W-1:0] r_inc;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic             interior;

  // beat acceptance: one pixel in flight, queue must have room
  assign full   = busy | q_full;
  assign accept = push & ~full;
  assign c_use  = ({1'b0, col_counter} >= image_width) ? '0 : col_counter;

  // line buffers: read on accept, write back in the cycle after
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_above <= line_above[c_use];
      rd_two   <= line_two_above[c_use];
    end
    if (busy) begin
      line_above[c_hold]     <= pix_hold;
      line_two_above[c_hold] <= rd_above;
    end
  end

  // raster position after this pixel
  always_comb begin
    c_inc    = {1'b0, c_hold} + 1'b1;
    r_inc    = {1'b0, row_counter} + 1'b1;
    col_next = c_inc[COL_W-1:0];
    row_next = row_counter;
    if (c_inc >= image_width) begin
      col_next = '0;
      row_next = (r_inc >= image_height) ? '0 : r_inc[ROW_W-1:0];
    end
  end

  // neighborhood differences for the interior pixel
  always_comb begin
    interior    = (row_counter >= ROW_W'(2)) && (c_hold >= COL_W'(2));
    q_push      = busy & interior;
    q_item.row  = row_counter - 1'b1;
    q_item.col  = c_hold - 1'b1;
    q_item.dx   = $signed({1'b0, rd_above}) - $signed({1'b0, w1});
    q_item.dy   = $signed({1'b0, w5}) - $signed({1'b0, w3});
    q_item.last = ({1'b0, row_counter} == image_height - 1'b1) &&
                  ({1'b0, c_hold} == image_width - 1'b1);
  end

  // registers, counters and window
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col_counter  <= '0;
      row_counter  <= '0;
      busy         <= 1'b0;
      w0 <= '0; w1 <= '0; w3 <= '0; w5 <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) image_width <= goc_clamp(cfg_data, WIDTH_MAX);
      else image_height <= goc_clamp(cfg_data, HEIGHT_MAX);
      col_counter <= '0;
      row_counter <= '0;
      w0 <= '0; w1 <= '0; w3 <= '0; w5 <= '0;
    end else if (busy) begin
      busy        <= 1'b0;
      w1          <= w0;
      w0          <= rd_above;
      w3          <= rd_two;
      w5          <= pix_hold;
      col_counter <= col_next;
      row_counter <= row_next;
    end else if (accept) begin
      busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_hold <= gray_pixel;
      c_hold   <= c_use;
    end
  end

endmodule
`default_nettype wire

// ----- design/goc_queue.sv -----
`default_nettype none
module goc_queue import goc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr,
  input  wire goc_item_t wr_item,
  input  wire logic      rd,
  output goc_item_t      rd_item,
  output logic           q_full,
  output logic           q_empty
);

  goc_item_t          slots [0:QDEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_item = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !q_full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !q_empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (wr && !rd) |=> count == $past(count) + 1'b1)
    else $error("queue level did not follow a write");
  a_bounded: assert property (@(posedge clk) count <= QCNT_W'(QDEPTH))
    else $error("queue level out of range");

endmodule
`default_nettype wire

// ----- design/goc_back.sv -----
`default_nettype none
module goc_back import goc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire goc_item_t         q_item,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [ROW_W-1:0]       row_index,
  output logic [COL_W-1:0]       col_index,
  output logic [7:0]             grad_magnitude,
  output logic signed [7:0]      grad_angle,
  output logic [2:0]             orientation_bin,
  output logic                   frame_last
);

  goc_back_state_t state, state_next;

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             last;
  logic             neg;
  logic [7:0]       ax, ay;
  logic [15:0]      sa, sb;
  logic [34:0]      n4;
  logic [16:0]      d;
  logic [7:0]       m;
  logic             eq;
  logic [2:0]       mbit;
  logic [17:0]      tsq;
  logic [6:0]       k;
  logic [2:0]       abit;
  logic             out_valid;

  logic       out_take;
  logic [7:0] m_cand;
  logic [8:0] t;
  logic [34:0] prod;
  logic [6:0] k_cand;
  logic [6:0] j_idx;
  logic [6:0] j_mir;
  logic [61:0] lhs, rhs;
  logic       ang_pass;
  logic [7:0] mag_fin;
  logic signed [7:0] ang_fin;
  logic [8:0] ang_ofs;
  logic [2:0] bin_fin;

  assign empty    = ~out_valid;
  assign out_take = ~out_valid | pop;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!q_empty) state_next = S_SQR;
      S_SQR:  state_next = S_SUM;
      S_SUM:  state_next = S_MAGA;
      S_MAGA: state_next = S_MAGB;
      S_MAGB: state_next = (mbit == 3'd0) ? S_ANG : S_MAGA;
      S_ANG:  if (abit == 3'd0) state_next = S_DONE;
      S_DONE: if (out_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop = 1'b0;
    case (state)
      S_IDLE:  q_pop = ~q_empty;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // magnitude search step: largest m with (2m-1)^2 * d <= 4(a^2+b^2)
  always_comb begin
    m_cand = m | (8'd1 << mbit);
    t      = {m_cand, 1'b0} - 1'b1;
    prod   = 35'(tsq) * 35'(d);
  end

  // angle search step: count of half-degree thresholds below dx/dy
  always_comb begin
    k_cand   = k | (7'd1 << abit);
    j_idx    = (k_cand <= 7'(ANG_STEPS)) ? k_cand - 1'b1 : '0;
    j_mir    = 7'(ANG_STEPS - 1) - j_idx;
    lhs      = 62'(ax) * 62'(SIN_Q54[j_mir]);
    rhs      = 62'(ay) * 62'(SIN_Q54[j_idx]);
    ang_pass = (k_cand <= 7'(ANG_STEPS)) && (lhs > rhs);
  end

  // special cases, sign and channel
  always_comb begin
    mag_fin = m - {7'd0, eq & m[0]};
    ang_fin = neg ? -$signed({1'b0, k}) : $signed({1'b0, k});
    if (ax == 8'd0 && ay == 8'd0) begin
      mag_fin = '0;
      ang_fin = ANG_NONE;
    end else if (ay == 8'd0) begin
      ang_fin = ANG_FLAT;
    end
    ang_ofs = 9'(ang_fin) + ANG_OFFSET;
    if (ang_ofs >= 9'd180) bin_fin = BIN_NONE;
    else if (ang_ofs >= 9'd150) bin_fin = 3'd5;
    else if (ang_ofs >= 9'd120) bin_fin = 3'd4;
    else if (ang_ofs >= 9'd90) bin_fin = 3'd3;
    else if (ang_ofs >= 9'd60) bin_fin = 3'd2;
    else if (ang_ofs >= 9'd30) bin_fin = 3'd1;
    else bin_fin = 3'd0;
  end

  // iterative datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        row  <= q_item.row;
        col  <= q_item.col;
        last <= q_item.last;
        neg  <= q_item.dx[8] != q_item.dy[8];
        ax   <= q_item.dx[8] ? 8'(-q_item.dx) : q_item.dx[7:0];
        ay   <= q_item.dy[8] ? 8'(-q_item.dy) : q_item.dy[7:0];
      end
      S_SQR: begin
        sa <= 16'(ax) * 16'(ax);
        sb <= 16'(ay) * 16'(ay);
      end
      S_SUM: begin
        n4   <= {(33'(32'(sa) * 32'(sa)) + 33'(32'(sb) * 32'(sb))), 2'b00};
        d    <= 17'(sa) + 17'(sb);
        m    <= '0;
        eq   <= 1'b0;
        mbit <= 3'd7;
      end
      S_MAGA: tsq <= 18'(t) * 18'(t);
      S_MAGB: begin
        if (prod <= n4) begin
          m  <= m_cand;
          eq <= (prod == n4);
        end
        mbit <= mbit - 1'b1;
        k    <= '0;
        abit <= 3'd6;
      end
      S_ANG: begin
        if (ang_pass) k <= k_cand;
        abit <= abit - 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_take) begin
      row_index       <= row;
      col_index       <= col;
      grad_magnitude  <= mag_fin;
      grad_angle      <= ang_fin;
      orientation_bin <= bin_fin;
      frame_last      <= last;
    end
  end

  a_mag_to_ang: assert property (@(posedge clk) disable iff (rst)
      (state == S_MAGB && mbit == 3'd0) |=> state == S_ANG)
    else $error("magnitude search did not hand over to angle search");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !pop) |=> out_valid && $stable(grad_magnitude))
    else $error("waiting result changed");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |-> state == S_IDLE)
    else $error("queue read outside idle");

endmodule
`default_nettype wire

// ----- design/gradient_orientation_channels.sv -----
// channel   beat on              payload
// pixels    push & !full         gray_pixel
// results   pop & !empty         row_index col_index grad_magnitude grad_angle
//                                orientation_bin frame_last
// config    cfg_we               cfg_index cfg_data
//
// each pixel passes the front as a line buffer read, then write-back
// an interior pixel passes the back as a bit-serial magnitude search
// (MAGA and MAGB per bit) and a 7-step angle search over the sine table
// a 4-deep queue between front and back buffers interior pixels
// synchronous reset; line buffers are not cleared and need no clearing pass
`default_nettype none
module gradient_orientation_channels import goc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       gray_pixel,
  output logic                  empty,
  input  wire logic             pop,
  output logic [9:0]            row_index,
  output logic [9:0]            col_index,
  output logic [7:0]            grad_magnitude,
  output logic signed [7:0]     grad_angle,
  output logic [2:0]            orientation_bin,
  output logic                  frame_last,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);

  goc_item_t front_item;
  goc_item_t head_item;
  logic      front_push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  // pixel intake and neighborhood
  goc_front u_front (
    .clk, .rst, .push, .gray_pixel, .cfg_we, .cfg_index, .cfg_data,
    .q_full, .full, .q_push(front_push), .q_item(front_item)
  );

  // decoupling queue
  goc_queue u_queue (
    .clk, .rst, .wr(front_push), .wr_item(front_item), .rd(q_pop),
    .rd_item(head_item), .q_full, .q_empty
  );

  // magnitude and orientation
  goc_back u_back (
    .clk, .rst, .q_item(head_item), .q_empty, .q_pop, .pop, .empty,
    .row_index, .col_index, .grad_magnitude, .grad_angle,
    .orientation_bin, .frame_last
  );

endmodule
`default_nettype wire

// ----- tb/goc_checker.sv -----
`default_nettype none
module goc_checker import goc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             full,
  input  wire logic [7:0]       gray_pixel,
  input  wire logic             empty,
  input  wire logic             pop,
  input  wire logic [9:0]       row_index,
  input  wire logic [9:0]       col_index,
  input  wire logic [7:0]       grad_magnitude,
  input  wire logic signed [7:0] grad_angle,
  input  wire logic [2:0]       orientation_bin,
  input  wire logic             frame_last,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] mag;
    logic [7:0] ang;
    logic [2:0] bin;
    logic       last;
  } grad_result_t;

  // predictor state
  logic [7:0]  above_line [0:MAX_WIDTH-1];
  logic [7:0]  two_above_line [0:MAX_WIDTH-1];
  logic [7:0]  win [0:5];
  int unsigned cur_row, cur_col, img_w, img_h;
  logic [63:0] sine_tab [0:89];
  grad_result_t expected_results [$];

  // sine of (j + 0.5) degrees, built from a taylor series in q62
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  task automatic build_sine_table();
    logic [63:0] step_val, x, x2, term, acc;
    step_val = 64'hC90FDAA22168C235 / 64'd360;
    for (int j = 0; j < 90; j++) begin
      x = step_val * (2 * j + 1);
      x2 = q62_product(x, x);
      term = x;
      acc = x;
      for (int k = 1; k <= 15; k++) begin
        term = q62_product(term, x2) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      sine_tab[j] = acc >> 8;
    end
  endtask

  function automatic int unsigned saturate(input logic [REG_W-1:0] v, input int unsigned hi);
    int unsigned x;
    x = v;
    if (x < 3) x = 3;
    if (x > hi) x = hi;
    return x;
  endfunction

  // round(sqrt((a^2+b^2)/(a+b))), halfway ties go to even
  function automatic int unsigned round_magnitude(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] num4, den, t;
    int unsigned m;
    num4 = 4 * (a * a + b * b);
    den = a + b;
    m = 0;
    for (int k = 1; k <= 255; k++) begin
      t = 2 * k - 1;
      if (t * t * den <= num4) m = k;
      else break;
    end
    if (m > 0) begin
      t = 2 * m - 1;
      if (t * t * den == num4 && m[0]) m--;
    end
    return m;
  endfunction

  function automatic int unsigned abs_angle(input logic [63:0] ax, input logic [63:0] ay);
    int unsigned n;
    n = 0;
    for (int j = 0; j < 90; j++)
      if (ax * sine_tab[89-j] > ay * sine_tab[j]) n++;
    return n;
  endfunction

  task automatic restart_frame();
    cur_row = 0;
    cur_col = 0;
    for (int i = 0; i < 6; i++) win[i] = 0;
  endtask

  // one pixel into the predictor
  task automatic predict_pixel(input logic [7:0] pix);
    int unsigned c, r, ax, ay, mag;
    int dx, dy, ang;
    logic [7:0] up, up2, left_cur;
    grad_result_t res;
    c = cur_col;
    r = cur_row;
    if (c >= img_w) c = 0;
    up = above_line[c];
    up2 = two_above_line[c];
    two_above_line[c] = up;
    above_line[c] = pix;
    win[2] = win[1];
    win[1] = win[0];
    win[0] = up;
    win[4] = win[3];
    win[3] = up2;
    left_cur = win[5];
    win[5] = pix;
    if (r >= 2 && c >= 2) begin
      dx = int'(win[0]) - int'(win[2]);
      dy = int'(left_cur) - int'(win[4]);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax == 0 && ay == 0) begin
        mag = 0;
        ang = 100;
      end else begin
        mag = round_magnitude(ax * ax, ay * ay);
        if (ay == 0) ang = -90;
        else begin
          ang = abs_angle(ax, ay);
          if ((dx < 0) != (dy < 0)) ang = -ang;
        end
      end
      res.row = 10'(r - 1);
      res.col = 10'(c - 1);
      res.mag = 8'(mag);
      res.ang = 8'(ang);
      res.bin = 3'((ang + 90) / 30);
      res.last = (r == img_h - 1 && c == img_w - 1);
      expected_results.push_back(res);
    end
    c++;
    if (c >= img_w) begin
      c = 0;
      r++;
      if (r >= img_h) r = 0;
    end
    cur_col = c;
    cur_row = r;
  endtask

  task automatic compare_beat();
    grad_result_t want, got;
    got = '{row_index, col_index, grad_magnitude, grad_angle, orientation_bin, frame_last};
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result beat %p", $time, got);
      errors++;
    end else begin
      want = expected_results.pop_front();
      if (got.row != want.row) begin
        $display("%0t: row_index exp %0d got %0d", $time, want.row, got.row); errors++;
      end
      if (got.col != want.col) begin
        $display("%0t: col_index exp %0d got %0d", $time, want.col, got.col); errors++;
      end
      if (got.mag != want.mag) begin
        $display("%0t: grad_magnitude exp %0d got %0d", $time, want.mag, got.mag); errors++;
      end
      if (got.ang != want.ang) begin
        $display("%0t: grad_angle exp %0d got %0d", $time,
                 $signed(want.ang), $signed(got.ang)); errors++;
      end
      if (got.bin != want.bin) begin
        $display("%0t: orientation_bin exp %0d got %0d", $time, want.bin, got.bin); errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: frame_last exp %0d got %0d", $time, want.last, got.last); errors++;
      end
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    build_sine_table();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      above_line[i] = 0;
      two_above_line[i] = 0;
    end
    img_w = 640;
    img_h = 480;
    restart_frame();
  end

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      img_w = 640;
      img_h = 480;
      restart_frame();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) img_w = saturate(cfg_data, MAX_WIDTH);
        else img_h = saturate(cfg_data, MAX_HEIGHT);
        restart_frame();
      end
      if (pop && !empty) compare_beat();
      if (push && !full) predict_pixel(gray_pixel);
    end
    pending = expected_results.size();
  end

endmodule
`default_nettype wire

// ----- tb/tb_gradient_orientation_channels.sv -----
`default_nettype none
module tb_gradient_orientation_channels import goc_pkg::*;;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic [7:0]       gray_pixel = 8'd0;
  logic             pop = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_WIDTH;
  logic [REG_W-1:0] cfg_data = '0;
  logic             full, empty, frame_last;
  logic [9:0]       row_index, col_index;
  logic [7:0]       grad_magnitude;
  logic signed [7:0] grad_angle;
  logic [2:0]       orientation_bin;
  int               errors, pending;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_cnt = 0;

  always #10 clk = ~clk;

  gradient_orientation_channels uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .gray_pixel(gray_pixel),
    .empty(empty), .pop(pop), .row_index(row_index), .col_index(col_index),
    .grad_magnitude(grad_magnitude), .grad_angle(grad_angle),
    .orientation_bin(orientation_bin), .frame_last(frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  goc_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .gray_pixel(gray_pixel),
    .empty(empty), .pop(pop), .row_index(row_index), .col_index(col_index),
    .grad_magnitude(grad_magnitude), .grad_angle(grad_angle),
    .orientation_bin(orientation_bin), .frame_last(frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one pixel beat, with a random gap after it
  task automatic send_pixel(input logic [7:0] v);
    gray_pixel <= v;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // textured content: noise, extremes, flat areas
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(3))
      0: return 8'($urandom);
      1: return $urandom_range(1) ? 8'd255 : 8'd0;
      2: return 8'(127 + $urandom_range(2));
      default: return 8'd77;
    endcase
  endfunction

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frames(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(pick_pixel());
  endtask

  // directed 5x5 frame: flat corner, vertical edge, strong horizontal step
  logic [7:0] directed_img [0:24] = '{
    8'd0,   8'd0,   8'd0,   8'd255, 8'd255,
    8'd0,   8'd0,   8'd0,   8'd255, 8'd255,
    8'd0,   8'd0,   8'd1,   8'd255, 8'd0,
    8'd255, 8'd0,   8'd255, 8'd0,   8'd128,
    8'd255, 8'd255, 8'd254, 8'd3,   8'd128
  };

  initial begin
    int unsigned w, h;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    write_reg(REG_WIDTH, 11'd5);
    write_reg(REG_HEIGHT, 11'd5);
    for (int i = 0; i < 25; i++) send_pixel(directed_img[i]);
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd1);
    send_frames(18);

    // random phases across idling modes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (int s = 0; s < 3; s++) begin
        w = $urandom_range(3, 16);
        h = $urandom_range(3, 8);
        write_reg(REG_WIDTH, 11'(w));
        write_reg(REG_HEIGHT, 11'(h));
        send_frames(w * h + $urandom_range(w));
      end
    end

    // back pressure: receiver holds off while pixels keep coming
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_WIDTH, 11'd20);
    write_reg(REG_HEIGHT, 11'd30);
    hold_req <= ~hold_req;
    send_frames(300);

    // largest sizes
    idle_pct = 10;
    stall_pct = 10;
    write_reg(REG_WIDTH, 11'h7FF);
    write_reg(REG_HEIGHT, 11'd3);
    send_frames(400);
    write_reg(REG_WIDTH, 11'd3);
    write_reg(REG_HEIGHT, 11'd1500);
    send_frames(30);

    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(20 * 4000000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
